// ===== rtl/json_string_unescape_utf8_macros.svh =====
// Assertion macros shared by the JSON string unescaper RTL.
// Included by the modules that carry concurrent checks; needs no package.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// Shared types and constants of the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and the top level; no dependencies.
package jsu_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_RES     = 4;
   localparam int RES_IDX_W   = $clog2(MAX_RES);
   localparam int RES_CNT_W   = $clog2(MAX_RES + 1);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_ERROR = 2'd2
   } jsu_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_NO_QUOTE    = 3'd1,
      ERR_INPUT_ENDED = 3'd2,
      ERR_BAD_HEX     = 3'd3,
      ERR_BAD_PAIR    = 3'd4,
      ERR_BAD_ESCAPE  = 3'd5
   } jsu_err_type;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_STR     = 3'd1,
      PH_ESC     = 3'd2,
      PH_HEX     = 3'd3,
      PH_AFTHI   = 3'd4,
      PH_AFTHIBS = 3'd5
   } jsu_phase_type;

   // All results caused by one input byte, in output order.
   typedef struct packed {
      logic [RES_CNT_W-1:0]      cnt;
      logic [MAX_RES-1:0][7:0]   data;
      jsu_kind_type [MAX_RES-1:0] kind;
      jsu_err_type               code;
   } jsu_group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jsu_qstat_type;

endpackage

// ===== rtl/jsu_front.sv =====
// Front end: parses the JSON string byte stream and builds at most one result group per byte.
// Depends on jsu_pkg; feeds jsu_queue.
module jsu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   output logic                  push,
   output jsu_pkg::jsu_group_type push_group
);

   jsu_pkg::jsu_phase_type phase_ff, phase_in;
   logic [11:0] accum_ff, accum_in;
   logic [1:0]  digits_ff, digits_in;
   logic [9:0]  high_ff, high_in;
   logic        low_ff, low_in;

   function automatic jsu_pkg::jsu_group_type utf8_encode(input logic [20:0] cp);
      jsu_pkg::jsu_group_type g;
      g      = '0;
      g.kind = '{default: jsu_pkg::KIND_DATA};
      g.code = jsu_pkg::ERR_NONE;
      if (cp <= 21'h7F) begin
         g.cnt     = 3'd1;
         g.data[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         g.cnt     = 3'd2;
         g.data[0] = {3'b110, cp[10:6]};
         g.data[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         g.cnt     = 3'd3;
         g.data[0] = {4'b1110, cp[15:12]};
         g.data[1] = {2'b10, cp[11:6]};
         g.data[2] = {2'b10, cp[5:0]};
      end else begin
         g.cnt     = 3'd4;
         g.data[0] = {5'b11110, cp[20:18]};
         g.data[1] = {2'b10, cp[17:12]};
         g.data[2] = {2'b10, cp[11:6]};
         g.data[3] = {2'b10, cp[5:0]};
      end
      return g;
   endfunction

   function automatic jsu_pkg::jsu_group_type make_error(input jsu_pkg::jsu_err_type c);
      jsu_pkg::jsu_group_type g;
      g         = '0;
      g.kind    = '{default: jsu_pkg::KIND_DATA};
      g.cnt     = 3'd1;
      g.kind[0] = jsu_pkg::KIND_ERROR;
      g.code    = c;
      return g;
   endfunction

   // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = '0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   // Bit 8 flags a simple escape letter, bits 7:0 carry the character it stands for.
   function automatic logic [8:0] esc_char(input logic [7:0] e);
      logic [8:0] r;
      case (e)
         8'h22:   r = {1'b1, 8'h22};
         8'h5C:   r = {1'b1, 8'h5C};
         8'h2F:   r = {1'b1, 8'h2F};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         default: r = '0;
      endcase
      return r;
   endfunction

   logic [4:0]  hex_v;
   logic [8:0]  esc_v;
   logic [15:0] acc_v;
   logic [20:0] cp_v;
   logic        pair_v;
   logic        is_low_v;
   jsu_pkg::jsu_group_type lone_v;
   jsu_pkg::jsu_group_type enc_v;

   assign hex_v    = hex_digit(in_byte);
   assign esc_v    = esc_char(in_byte);
   assign acc_v    = {accum_ff, hex_v[3:0]};
   assign is_low_v = (acc_v[15:10] == 6'b110111);
   assign pair_v   = low_ff && is_low_v;
   // A paired code point is 0x10000 plus the two ten-bit halves side by side.
   assign cp_v     = pair_v ? (21'h10000 + {1'b0, high_ff, acc_v[9:0]}) : {5'b0, acc_v};
   assign enc_v    = utf8_encode(cp_v);
   assign lone_v   = utf8_encode({5'b0, 6'b110110, high_ff});

   always_comb begin
      jsu_pkg::jsu_group_type g;
      logic use_str;
      logic use_esc;
      logic go_idle;
      phase_in  = phase_ff;
      accum_in  = accum_ff;
      digits_in = digits_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      g         = '0;
      g.kind    = '{default: jsu_pkg::KIND_DATA};
      g.code    = jsu_pkg::ERR_NONE;
      use_str   = 1'b0;
      use_esc   = 1'b0;
      go_idle   = 1'b0;

      if (req_fire) begin
         case (phase_ff)
            jsu_pkg::PH_STR: begin
               use_str = 1'b1;
            end
            jsu_pkg::PH_ESC: begin
               use_esc = 1'b1;
            end
            jsu_pkg::PH_HEX: begin
               if (in_last) begin
                  g       = make_error(jsu_pkg::ERR_INPUT_ENDED);
                  go_idle = 1'b1;
               end else if (!hex_v[4]) begin
                  g       = make_error(jsu_pkg::ERR_BAD_HEX);
                  go_idle = 1'b1;
               end else if (digits_ff != 2'd3) begin
                  accum_in  = acc_v[11:0];
                  digits_in = digits_ff + 2'd1;
               end else begin
                  accum_in  = '0;
                  digits_in = '0;
                  if (low_ff) begin
                     if (is_low_v) begin
                        g        = enc_v;
                        high_in  = '0;
                        low_in   = 1'b0;
                        phase_in = jsu_pkg::PH_STR;
                     end else begin
                        g       = make_error(jsu_pkg::ERR_BAD_PAIR);
                        go_idle = 1'b1;
                     end
                  end else if (acc_v[15:10] == 6'b110110) begin
                     high_in  = acc_v[9:0];
                     phase_in = jsu_pkg::PH_AFTHI;
                  end else begin
                     g        = enc_v;
                     phase_in = jsu_pkg::PH_STR;
                  end
               end
            end
            jsu_pkg::PH_AFTHI: begin
               if (in_byte == jsu_pkg::CH_BSLASH) begin
                  if (in_last) begin
                     g       = make_error(jsu_pkg::ERR_INPUT_ENDED);
                     go_idle = 1'b1;
                  end else begin
                     phase_in = jsu_pkg::PH_AFTHIBS;
                  end
               end else begin
                  // The high surrogate stands alone; the byte is then ordinary string text.
                  g        = lone_v;
                  high_in  = '0;
                  phase_in = jsu_pkg::PH_STR;
                  use_str  = 1'b1;
               end
            end
            jsu_pkg::PH_AFTHIBS: begin
               if (in_byte == jsu_pkg::CH_U) begin
                  if (in_last) begin
                     g       = make_error(jsu_pkg::ERR_INPUT_ENDED);
                     go_idle = 1'b1;
                  end else begin
                     accum_in  = '0;
                     digits_in = '0;
                     low_in    = 1'b1;
                     phase_in  = jsu_pkg::PH_HEX;
                  end
               end else begin
                  g        = lone_v;
                  high_in  = '0;
                  phase_in = jsu_pkg::PH_STR;
                  use_esc  = 1'b1;
               end
            end
            default: begin
               go_idle = 1'b1;
               if (in_byte != jsu_pkg::CH_QUOTE) begin
                  g = make_error(jsu_pkg::ERR_NO_QUOTE);
               end else if (in_last) begin
                  g = make_error(jsu_pkg::ERR_INPUT_ENDED);
               end else begin
                  go_idle = 1'b0;
                  accum_in  = '0;
                  digits_in = '0;
                  high_in   = '0;
                  low_in    = 1'b0;
                  phase_in  = jsu_pkg::PH_STR;
               end
            end
         endcase

         if (use_str) begin
            if (in_byte == jsu_pkg::CH_QUOTE) begin
               g.kind[g.cnt[jsu_pkg::RES_IDX_W-1:0]] = jsu_pkg::KIND_CLOSE;
               g.data[g.cnt[jsu_pkg::RES_IDX_W-1:0]] = '0;
               g.cnt   = g.cnt + 3'd1;
               go_idle = 1'b1;
            end else if (in_last) begin
               g       = make_error(jsu_pkg::ERR_INPUT_ENDED);
               go_idle = 1'b1;
            end else if (in_byte == jsu_pkg::CH_BSLASH) begin
               phase_in = jsu_pkg::PH_ESC;
            end else begin
               g.kind[g.cnt[jsu_pkg::RES_IDX_W-1:0]] = jsu_pkg::KIND_DATA;
               g.data[g.cnt[jsu_pkg::RES_IDX_W-1:0]] = in_byte;
               g.cnt    = g.cnt + 3'd1;
               phase_in = jsu_pkg::PH_STR;
            end
         end

         if (use_esc) begin
            if (esc_v[8]) begin
               if (in_last) begin
                  g       = make_error(jsu_pkg::ERR_INPUT_ENDED);
                  go_idle = 1'b1;
               end else begin
                  g.kind[g.cnt[jsu_pkg::RES_IDX_W-1:0]] = jsu_pkg::KIND_DATA;
                  g.data[g.cnt[jsu_pkg::RES_IDX_W-1:0]] = esc_v[7:0];
                  g.cnt    = g.cnt + 3'd1;
                  phase_in = jsu_pkg::PH_STR;
               end
            end else if (in_byte == jsu_pkg::CH_U) begin
               if (in_last) begin
                  g       = make_error(jsu_pkg::ERR_INPUT_ENDED);
                  go_idle = 1'b1;
               end else begin
                  accum_in  = '0;
                  digits_in = '0;
                  low_in    = 1'b0;
                  phase_in  = jsu_pkg::PH_HEX;
               end
            end else begin
               g       = make_error(jsu_pkg::ERR_BAD_ESCAPE);
               go_idle = 1'b1;
            end
         end

         if (go_idle) begin
            phase_in  = jsu_pkg::PH_IDLE;
            accum_in  = '0;
            digits_in = '0;
            high_in   = '0;
            low_in    = 1'b0;
         end
      end

      push_group = g;
      push       = req_fire && (g.cnt != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= jsu_pkg::PH_IDLE;
         accum_ff  <= '0;
         digits_ff <= '0;
         high_ff   <= '0;
         low_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         accum_ff  <= accum_in;
         digits_ff <= digits_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
      end
   end

endmodule

// ===== rtl/jsu_queue.sv =====
// Short queue of result groups between the parser and the output serialiser.
// Depends on jsu_pkg.
module jsu_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  jsu_pkg::jsu_group_type push_group,
   input  logic                   pop,
   output jsu_pkg::jsu_group_type head_group,
   output jsu_pkg::jsu_qstat_type qstat
);

   jsu_pkg::jsu_group_type slot_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::QCNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign qstat.full  = (count_ff == jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_group  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: serialises queued result groups into single results on a registered output.
// Depends on jsu_pkg; drains jsu_queue.
module jsu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  jsu_pkg::jsu_group_type head_group,
   input  jsu_pkg::jsu_qstat_type qstat,
   output logic                   pop,
   input  logic                   out_ready,
   output logic                   out_valid,
   output logic [7:0]             out_byte,
   output jsu_pkg::jsu_kind_type  out_kind,
   output jsu_pkg::jsu_err_type   out_code,
   output logic                   out_last
);

   logic [jsu_pkg::RES_IDX_W-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff;
   jsu_pkg::jsu_kind_type kind_ff;
   jsu_pkg::jsu_err_type  code_ff;
   logic                  last_ff;
   logic                  load;
   logic                  at_end;

   // The output register takes a new result when the queue holds a group and the register is empty or being drained.
   assign load   = !qstat.empty && (!valid_ff || out_ready);
   assign at_end = ({1'b0, idx_ff} == (head_group.cnt - 1'b1));
   assign pop    = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = at_end ? '0 : idx_ff + 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head_group.data[idx_ff];
         kind_ff <= head_group.kind[idx_ff];
         code_ff <= (head_group.kind[idx_ff] == jsu_pkg::KIND_ERROR) ?
                    head_group.code : jsu_pkg::ERR_NONE;
         last_ff <= at_end;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_kind  = kind_ff;
   assign out_code  = code_ff;
   assign out_last  = last_ff;

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// JSON string unescaper top level: parser front end, group queue, output serialiser.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back and json_string_unescape_utf8_macros.svh.
//
// Usage: the text enters on the req_ channel one byte per transaction, req_tlast marking
// the final byte of the available input. Each byte gives zero to four results on the
// rsp_ channel: decoded data bytes, a closed-string marker or a single error, with
// rsp_tlast set on the last result caused by that byte. A byte that gives no result
// (an opening quote, a backslash, a hex digit inside a run) produces nothing.
// The first result of a byte passes through the queue slot and then the output register
// before it is presented on rsp_.
// Throughput: one byte per cycle while each byte yields at most one result and the
// receiver holds rsp_tready high; the output register issues one result per cycle
// while rsp_tready is high. A four-entry queue of result groups absorbs the bursts of
// multi-byte results, and req_tready falls only when that queue is full.
// When the receiver stalls, the current result holds on rsp_ and the queue fills behind
// it; the parser keeps accepting bytes until the queue is full.
// Reset empties the queue and the output register and returns the parser to idle,
// waiting for an opening quote. Reset is synchronous and active high.
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // in_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [10:8] error_code, [15:11] zero
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   output logic        rsp_tlast    // out_last
);

   logic                   req_fire;
   logic                   push;
   logic                   pop;
   jsu_pkg::jsu_group_type push_group;
   jsu_pkg::jsu_group_type head_group;
   jsu_pkg::jsu_qstat_type qstat;
   logic [7:0]             out_byte;
   jsu_pkg::jsu_kind_type  out_kind;
   jsu_pkg::jsu_err_type   out_code;
   logic                   rsp_is_error;
   logic                   rsp_is_close;

   assign req_tready = !qstat.full;
   assign req_fire   = req_tvalid && req_tready;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .push       (push),
      .push_group (push_group)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head_group (head_group),
      .qstat      (qstat)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_group (head_group),
      .qstat      (qstat),
      .pop        (pop),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_byte   (out_byte),
      .out_kind   (out_kind),
      .out_code   (out_code),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, out_code, out_byte};
   assign rsp_tuser = out_kind;

   assign rsp_is_error = rsp_tvalid && (out_kind == jsu_pkg::KIND_ERROR);
   assign rsp_is_close = rsp_tvalid && (out_kind == jsu_pkg::KIND_CLOSE);

   // The front end must never hand a group to a full queue, nor the back end pop an empty one.
   `JSU_ASSERT_NOW(a_push_not_full, clock, reset, push, !qstat.full, "push into full queue")
   `JSU_ASSERT_NOW(a_pop_not_empty, clock, reset, pop, !qstat.empty, "pop from empty queue")
   `JSU_ASSERT_NEXT(a_push_fills, clock, reset, push && qstat.empty, !qstat.empty, "group lost")
   // An error or a closed string always ends the results of its byte.
   `JSU_ASSERT_NOW(a_error_last, clock, reset, rsp_is_error, rsp_tlast, "error not last")
   `JSU_ASSERT_NOW(a_close_last, clock, reset, rsp_is_close, rsp_tlast, "close not last")

endmodule
